FILE: hw/rtl/poc_pkg.sv
package poc_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int TEXT_MAX    = 65536;

    localparam int BYTE_W     = 8;
    localparam int PAT_W      = MAX_PATTERN * BYTE_W;
    localparam int LEN_W      = 4;
    localparam int POS_W      = $clog2(TEXT_MAX) + 1;
    localparam int COUNT_W    = 17;
    localparam int START_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int WIN_IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    localparam logic [COUNT_W-1:0] COUNT_SAT   = '1;
    localparam logic [POS_W-1:0]   POS_LIMIT   = POS_W'(TEXT_MAX);
    localparam logic [LEN_W-1:0]   LEN_MAX     = LEN_W'(MAX_PATTERN);
    localparam logic [LEN_W-1:0]   LEN_RESET   = LEN_W'(1);

    localparam logic [BYTE_W-1:0]  CHAR_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0]  CHAR_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0]  CHAR_LOWER_A = 8'h61;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_BYTES  = 2'd0,
        REG_PATTERN_LENGTH = 2'd1,
        REG_IGNORE_CASE    = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [PAT_W-1:0] pattern_bytes;
        logic [LEN_W-1:0] pattern_length;
        logic             ignore_case;
    } cfg_regs_t;

    function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] c, input logic on);
        logic [BYTE_W-1:0] res;
        res = c;
        if (on && (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}))
        begin
            res = c - CHAR_UPPER_A + CHAR_LOWER_A;
        end
        return res;
    endfunction

endpackage

FILE: hw/rtl/poc_if.sv
interface poc_text_if;
    logic                        valid;
    logic                        ready;
    logic [poc_pkg::BYTE_W-1:0]  text_byte;
    logic                        last_byte;

    modport source (output valid, output text_byte, output last_byte, input ready);
    modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface poc_result_if;
    logic                         valid;
    logic                         ready;
    logic                         match_found;
    logic [poc_pkg::START_W-1:0]  match_start;
    logic [poc_pkg::COUNT_W-1:0]  match_total;
    logic                         text_overflow;
    logic                         text_done;

    modport source (output valid, output match_found, output match_start,
                    output match_total, output text_overflow, output text_done,
                    input ready);
    modport sink   (input valid, input match_found, input match_start,
                    input match_total, input text_overflow, input text_done,
                    output ready);
endinterface

interface poc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [poc_pkg::CFG_IDX_W-1:0]   index;
    logic [poc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/pattern_occurrence_counter_unit.sv
// Pattern occurrence counter.
// text_in takes one text byte per transfer with a last_byte mark; result_out
// gives one result per byte: match_found, match_start, match_total,
// text_overflow and text_done. cfg writes pattern_bytes (index 0),
// pattern_length (index 1) and ignore_case (index 2); it is always ready and
// is to be written only while no bytes are in flight.
// Each accepted byte is held in the input register, is evaluated against the
// window and counters, and its result is loaded into the result register.
// Throughput is one byte per cycle unless result_out stalls: the window
// compare is a parallel check of up to 8 bytes and the position/count
// update is one add. When result_out stalls, the input register holds its
// byte and text_in ready drops once both registers are full.
// A byte with last_byte set reports its result, then the window, position,
// next allowed start and count clear for the next text.
// Reset (rst_n low) empties both registers, clears all text state and sets
// the pattern to 0, length to 1 and case folding off.
module pattern_occurrence_counter_unit (
    input  logic   clk,
    input  logic   rst_n,
    poc_text_if.sink     text_in,
    poc_result_if.source result_out,
    poc_cfg_if.sink      cfg
);

    poc_pkg::cfg_regs_t cfg_regs_reg;

    logic                        s1_valid_reg;
    logic [poc_pkg::BYTE_W-1:0]  s1_byte_reg;
    logic                        s1_last_reg;

    logic [poc_pkg::PAT_W-1:0]   window_reg;
    logic [poc_pkg::POS_W-1:0]   pos_reg;
    logic [poc_pkg::POS_W-1:0]   nas_reg;
    logic [poc_pkg::COUNT_W-1:0] count_reg;

    logic                        out_valid_reg;
    logic                        out_found_reg;
    logic [poc_pkg::START_W-1:0] out_start_reg;
    logic [poc_pkg::COUNT_W-1:0] out_total_reg;
    logic                        out_overflow_reg;
    logic                        out_done_reg;

    logic                        out_can_load;
    logic                        s1_fire;
    logic                        in_fire;
    logic                        overflow;
    logic [poc_pkg::LEN_W-1:0]   len_eff;
    logic [poc_pkg::PAT_W-1:0]   window_next;
    logic [poc_pkg::POS_W-1:0]   pos_next;
    logic [poc_pkg::POS_W-1:0]   start_ofs;
    logic                        start_ok;
    logic                        hit;
    logic                        found;
    logic [poc_pkg::COUNT_W-1:0] count_next;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_regs_reg.pattern_bytes  <= '0;
            cfg_regs_reg.pattern_length <= poc_pkg::LEN_RESET;
            cfg_regs_reg.ignore_case    <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                poc_pkg::REG_PATTERN_BYTES:
                begin
                    cfg_regs_reg.pattern_bytes <= cfg.data[poc_pkg::PAT_W-1:0];
                end
                poc_pkg::REG_PATTERN_LENGTH:
                begin
                    cfg_regs_reg.pattern_length <= cfg.data[poc_pkg::LEN_W-1:0];
                end
                poc_pkg::REG_IGNORE_CASE:
                begin
                    cfg_regs_reg.ignore_case <= cfg.data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_can_load  = !out_valid_reg || result_out.ready;
    assign s1_fire       = s1_valid_reg && out_can_load;
    assign text_in.ready = !s1_valid_reg || out_can_load;
    assign in_fire       = text_in.valid && text_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg <= text_in.text_byte;
            s1_last_reg <= text_in.last_byte;
        end
    end

    assign overflow    = (pos_reg >= poc_pkg::POS_LIMIT);
    assign len_eff     = (cfg_regs_reg.pattern_length > poc_pkg::LEN_MAX) ?
                         poc_pkg::LEN_MAX : cfg_regs_reg.pattern_length;
    assign window_next = {window_reg[poc_pkg::PAT_W-poc_pkg::BYTE_W-1:0], s1_byte_reg};
    assign pos_next    = pos_reg + poc_pkg::POS_W'(1);
    assign start_ofs   = pos_next - poc_pkg::POS_W'(len_eff);
    assign start_ok    = (pos_next >= poc_pkg::POS_W'(len_eff)) && (start_ofs >= nas_reg);

    poc_match u_match (
        .window   (window_next),
        .cfg_regs (cfg_regs_reg),
        .len_eff  (len_eff),
        .hit      (hit)
    );

    assign found      = !overflow && start_ok && hit;
    assign count_next = (found && (count_reg != poc_pkg::COUNT_SAT)) ?
                        count_reg + poc_pkg::COUNT_W'(1) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            pos_reg    <= '0;
            nas_reg    <= '0;
            count_reg  <= '0;
        end
        else if (s1_fire)
        begin
            if (s1_last_reg)
            begin
                window_reg <= '0;
                pos_reg    <= '0;
                nas_reg    <= '0;
                count_reg  <= '0;
            end
            else if (!overflow)
            begin
                window_reg <= window_next;
                pos_reg    <= pos_next;
                count_reg  <= count_next;
                if (found)
                begin
                    nas_reg <= pos_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_found_reg    <= found;
            out_start_reg    <= found ? start_ofs[poc_pkg::START_W-1:0] : '0;
            out_total_reg    <= count_next;
            out_overflow_reg <= overflow;
            out_done_reg     <= s1_last_reg;
        end
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.match_found   = out_found_reg;
    assign result_out.match_start   = out_start_reg;
    assign result_out.match_total   = out_total_reg;
    assign result_out.text_overflow = out_overflow_reg;
    assign result_out.text_done     = out_done_reg;

endmodule

FILE: hw/rtl/poc_match.sv
module poc_match (
    input  logic [poc_pkg::PAT_W-1:0]  window,
    input  poc_pkg::cfg_regs_t         cfg_regs,
    input  logic [poc_pkg::LEN_W-1:0]  len_eff,
    output logic                       hit
);

    logic [poc_pkg::LEN_W-1:0]     tap;
    logic [poc_pkg::WIN_IDX_W-1:0] idx;
    logic [poc_pkg::BYTE_W-1:0]    pat_byte;
    logic [poc_pkg::BYTE_W-1:0]    txt_byte;

    // pattern byte i lines up with window entry len-1-i (entry 0 is newest)
    always_comb
    begin
        hit      = (len_eff != '0);
        tap      = '0;
        idx      = '0;
        pat_byte = '0;
        txt_byte = '0;
        for (int i = 0; i < poc_pkg::MAX_PATTERN; i++)
        begin
            if (poc_pkg::LEN_W'(i) < len_eff)
            begin
                tap      = len_eff - poc_pkg::LEN_W'(i) - poc_pkg::LEN_W'(1);
                idx      = tap[poc_pkg::WIN_IDX_W-1:0];
                pat_byte = cfg_regs.pattern_bytes[i*poc_pkg::BYTE_W +: poc_pkg::BYTE_W];
                txt_byte = window[idx*poc_pkg::BYTE_W +: poc_pkg::BYTE_W];
                if (poc_pkg::fold(pat_byte, cfg_regs.ignore_case) !=
                    poc_pkg::fold(txt_byte, cfg_regs.ignore_case))
                begin
                    hit = 1'b0;
                end
            end
        end
    end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps

module tb;

    typedef struct {
        logic                        found;
        logic [poc_pkg::START_W-1:0] start;
        logic [poc_pkg::COUNT_W-1:0] total;
        logic                        overflow;
        logic                        done;
    } scan_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    poc_text_if   text_ch ();
    poc_result_if result_ch ();
    poc_cfg_if    cfg_ch ();

    pattern_occurrence_counter_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_in    (text_ch),
        .result_out (result_ch),
        .cfg        (cfg_ch)
    );

    // predictor state and register shadow
    logic [poc_pkg::PAT_W-1:0]  cur_pattern = '0;
    logic [poc_pkg::LEN_W-1:0]  cur_length  = poc_pkg::LEN_RESET;
    logic                       cur_fold    = 1'b0;
    logic [poc_pkg::BYTE_W-1:0] window_bytes [poc_pkg::MAX_PATTERN];
    int unsigned                text_pos;
    int unsigned                next_start;
    int unsigned                match_count;

    scan_result_t awaited_results [$];

    int error_count   = 0;
    int result_index  = 0;
    int items_sent    = 0;
    int texts_closed  = 0;
    int matches_seen  = 0;
    int reg_writes    = 0;
    int send_idle     = 1;
    int drain_idle    = 1;
    int pressure_hold = 0;

    function automatic logic [poc_pkg::BYTE_W-1:0] lower_if(input logic [poc_pkg::BYTE_W-1:0] c,
                                                            input logic on);
        if (on && c >= poc_pkg::CHAR_UPPER_A && c <= poc_pkg::CHAR_UPPER_Z)
        begin
            return c + (poc_pkg::CHAR_LOWER_A - poc_pkg::CHAR_UPPER_A);
        end
        return c;
    endfunction

    function automatic logic [poc_pkg::BYTE_W-1:0] swap_case(input logic [poc_pkg::BYTE_W-1:0] c);
        if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z"))
        begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    function automatic int draw_gap(input int level);
        case (level)
            0:       return 0;
            1:       return $urandom_range(0, 16);
            default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
        endcase
    endfunction

    task automatic clear_text_state();
        for (int k = 0; k < poc_pkg::MAX_PATTERN; k++)
        begin
            window_bytes[k] = '0;
        end
        text_pos    = 0;
        next_start  = 0;
        match_count = 0;
    endtask

    task automatic count_pattern_byte(input logic [poc_pkg::BYTE_W-1:0] b, input logic last);
        scan_result_t r;
        int unsigned  span;
        int unsigned  s;
        logic         hit;
        r = '{default: '0};
        if (text_pos >= poc_pkg::TEXT_MAX)
        begin
            r.overflow = 1'b1;
        end
        else
        begin
            span = (cur_length > poc_pkg::LEN_MAX) ? 32'(poc_pkg::MAX_PATTERN)
                                                   : 32'(cur_length);
            for (int k = poc_pkg::MAX_PATTERN - 1; k > 0; k--)
            begin
                window_bytes[k] = window_bytes[k-1];
            end
            window_bytes[0] = b;
            if (span > 0 && text_pos + 1 >= span)
            begin
                s = text_pos + 1 - span;
                if (s >= next_start)
                begin
                    hit = 1'b1;
                    for (int i = 0; i < span; i++)
                    begin
                        if (lower_if(cur_pattern[8*i +: 8], cur_fold)
                            != lower_if(window_bytes[span-1-i], cur_fold))
                        begin
                            hit = 1'b0;
                        end
                    end
                    if (hit)
                    begin
                        r.found = 1'b1;
                        r.start = s[poc_pkg::START_W-1:0];
                        if (match_count < int'(poc_pkg::COUNT_SAT))
                        begin
                            match_count++;
                        end
                        next_start = text_pos + 1;
                    end
                end
            end
            text_pos++;
        end
        r.total = match_count[poc_pkg::COUNT_W-1:0];
        r.done  = last;
        awaited_results.push_back(r);
        if (last)
        begin
            clear_text_state();
        end
    endtask

    task automatic report_mismatch(input string what, input longint want, input longint got);
        error_count++;
        $display("ERROR %0t: result %0d %s expected %0d got %0d",
                 $time, result_index, what, want, got);
    endtask

    always @(posedge clk)
    begin : check_results
        scan_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (awaited_results.size() == 0)
            begin
                report_mismatch("unexpected transfer", 0, 1);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (result_ch.match_found !== want.found)
                    report_mismatch("match_found", want.found, result_ch.match_found);
                if (result_ch.match_start !== want.start)
                    report_mismatch("match_start", want.start, result_ch.match_start);
                if (result_ch.match_total !== want.total)
                    report_mismatch("match_total", want.total, result_ch.match_total);
                if (result_ch.text_overflow !== want.overflow)
                    report_mismatch("text_overflow", want.overflow, result_ch.text_overflow);
                if (result_ch.text_done !== want.done)
                    report_mismatch("text_done", want.done, result_ch.text_done);
            end
            if (result_ch.match_found === 1'b1)
            begin
                matches_seen++;
            end
            result_index++;
        end
    end

    // result side: random stalls per transfer, plus a long hold when asked
    initial
    begin : drain_results
        int stall;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = draw_gap(drain_idle);
            if (pressure_hold > 0)
            begin
                stall = pressure_hold;
                pressure_hold = 0;
            end
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (result_ch.valid !== 1'b1);
        end
    end

    task automatic send_byte(input logic [poc_pkg::BYTE_W-1:0] b, input logic last);
        int gap;
        gap = draw_gap(send_idle);
        if (gap > 0)
        begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_ch.valid     <= 1'b1;
        text_ch.text_byte <= b;
        text_ch.last_byte <= last;
        do @(posedge clk); while (text_ch.ready !== 1'b1);
        count_pattern_byte(b, last);
        items_sent++;
        if (last)
        begin
            texts_closed++;
        end
    endtask

    task automatic send_text(input string s, input logic close);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i], close && (i == s.len() - 1));
        end
    endtask

    task automatic wait_drained();
        text_ch.valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input poc_pkg::cfg_index_t idx,
                             input logic [poc_pkg::CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        case (idx)
            poc_pkg::REG_PATTERN_BYTES:  cur_pattern = value;
            poc_pkg::REG_PATTERN_LENGTH: cur_length  = value[poc_pkg::LEN_W-1:0];
            poc_pkg::REG_IGNORE_CASE:    cur_fold    = value[0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic set_config(input logic [poc_pkg::PAT_W-1:0] pat,
                              input logic [poc_pkg::LEN_W-1:0] len,
                              input logic fold);
        wait_drained();
        write_reg(poc_pkg::REG_PATTERN_BYTES, pat);
        write_reg(poc_pkg::REG_PATTERN_LENGTH, {$urandom(), 28'($urandom()), len});
        write_reg(poc_pkg::REG_IGNORE_CASE, {$urandom(), 31'($urandom()), fold});
        cfg_ch.valid <= 1'b0;
    endtask

    // pattern 0, length 1 after reset: a zero byte is a match
    task automatic test_reset_defaults();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_case_folding();
        set_config(64'hFFFF_0000_0000_615A, 4'd2, 1'b1);
        send_text("zA@[`{Za", 1'b1);
    endtask

    task automatic test_overlap_short();
        set_config(64'h0000_0000_0000_6161, 4'd2, 1'b0);
        send_text("aaaaa", 1'b1);
        set_config(64'h0000_0000_6161_6161, 4'd4, 1'b0);
        send_text("aa", 1'b1);
    endtask

    task automatic test_length_edges();
        set_config('1, 4'd0, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        set_config('1, 4'd15, 1'b1);
        for (int i = 0; i < 9; i++)
        begin
            send_byte(8'hFF, i == 8);
        end
    endtask

    task automatic test_backpressure();
        set_config(64'h0000_0000_0000_6261, 4'd2, 1'b0);
        send_idle  = 0;
        drain_idle = 0;
        pressure_hold = 300;
        for (int i = 0; i < 40; i++)
        begin
            send_byte($urandom_range(0, 1) ? "a" : "b", i == 39);
        end
    endtask

    task automatic test_random_texts();
        int                         produced;
        int                         phase;
        int                         chunk;
        int                         span;
        logic [poc_pkg::PAT_W-1:0]  pat;
        logic [poc_pkg::LEN_W-1:0]  len;
        logic                       fold;
        logic [poc_pkg::BYTE_W-1:0] b;
        produced = 0;
        phase    = 0;
        while (produced < 580)
        begin
            case (phase)
                0:       len = 4'd8;
                1:       len = 4'd1;
                default: len = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                           : 4'($urandom_range(1, 4));
            endcase
            if ($urandom_range(0, 3) == 0)
            begin
                pat = {$urandom(), $urandom()};
            end
            else
            begin
                for (int i = 0; i < poc_pkg::MAX_PATTERN; i++)
                begin
                    pat[8*i +: 8] = "a" + 8'($urandom_range(0, 3));
                    if ($urandom_range(0, 1))
                        pat[8*i +: 8] = swap_case(pat[8*i +: 8]);
                end
            end
            fold = 1'($urandom_range(0, 1));
            set_config(pat, len, fold);
            send_idle  = $urandom_range(0, 2);
            drain_idle = $urandom_range(0, 2);
            span = (len > poc_pkg::LEN_MAX) ? poc_pkg::MAX_PATTERN : int'(len);
            chunk = 0;
            // texts left open at the end of a phase run on under the next setting
            while (chunk < 50)
            begin
                if ($urandom_range(0, 9) < 4 && span > 0)
                begin
                    for (int i = 0; i < span; i++)
                    begin
                        b = pat[8*i +: 8];
                        if (fold && $urandom_range(0, 1))
                            b = swap_case(b);
                        if ($urandom_range(0, 9) == 0)
                            b = 8'($urandom_range(0, 255));
                        send_byte(b, $urandom_range(0, 24) == 0);
                        chunk++;
                    end
                end
                else
                begin
                    if ($urandom_range(0, 4) == 0)
                        b = 8'($urandom_range(0, 255));
                    else
                        b = swap_case(pat[8*$urandom_range(0, poc_pkg::MAX_PATTERN - 1) +: 8]);
                    send_byte(b, $urandom_range(0, 24) == 0);
                    chunk++;
                end
            end
            produced += chunk;
            phase++;
        end
    endtask

    initial
    begin
        #5_000_000;
        $display("pattern_occurrence_counter_unit test failed");
        $finish;
    end

    initial
    begin : run_tests
        int guard;
        text_ch.valid     <= 1'b0;
        text_ch.text_byte <= '0;
        text_ch.last_byte <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= poc_pkg::REG_PATTERN_BYTES;
        cfg_ch.data       <= '0;
        clear_text_state();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_case_folding();
        test_overlap_short();
        test_length_edges();
        test_backpressure();
        send_idle  = 1;
        drain_idle = 1;
        test_random_texts();

        text_ch.valid <= 1'b0;
        for (guard = 0; guard < 2000 && awaited_results.size() != 0; guard++)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (awaited_results.size() != 0)
        begin
            report_mismatch("results never delivered", 0, awaited_results.size());
        end

        $display("Streamed %0d bytes in %0d closed texts, %0d counted matches.",
                 items_sent, texts_closed, matches_seen);
        $display("Register writes: %0d, mismatches: %0d.", reg_writes, error_count);
        if (error_count == 0)
        begin
            $display("pattern_occurrence_counter_unit test passed");
        end
        else
        begin
            $display("pattern_occurrence_counter_unit test failed");
        end
        $finish;
    end

endmodule
